/* hw/rtl/nopf_pkg.sv */
// Shared constants and types of the neighbor outlier pixel filter.
package nopf_pkg;

	localparam int LEVEL_WIDTH    = 16;
	localparam int SLOT_COUNT     = 4;
	localparam int SLOT_IDX_WIDTH = $clog2(SLOT_COUNT);
	localparam int COUNT_WIDTH    = $clog2(SLOT_COUNT + 1);
	localparam int HEAD_DEPTH     = 3;
	localparam int POS_WIDTH      = 3;

	// Frame position codes: below POS_HEAD_DONE the head pixels are still collected
	localparam logic [POS_WIDTH-1:0] POS_HEAD_DONE = 3'd3;
	localparam logic [POS_WIDTH-1:0] POS_STEADY    = 3'd4;

	// Burst hand-over from the tracker to the result buffer
	typedef struct packed {
		logic                   load;
		logic [COUNT_WIDTH-1:0] count;
	} burst_ctl_t;

	// Per-slot flags: judge at drain time, stored replaced bit, frame end
	typedef struct packed {
		logic judge;
		logic replaced;
		logic last;
	} slot_flags_t;

endpackage

/* hw/rtl/nopf_in_if.sv */
// Pixel input channel: valid/ready handshake with pixel and frame end mark.
interface nopf_in_if #(
	parameter int PIXEL_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [PIXEL_WIDTH-1:0] pixel_in;
	logic                          frame_end_in;

	modport source (output valid, output pixel_in, output frame_end_in, input ready);
	modport sink   (input valid, input pixel_in, input frame_end_in, output ready);
endinterface

/* hw/rtl/nopf_out_if.sv */
// Result output channel: valid/ready handshake with filtered pixel and flags.
interface nopf_out_if #(
	parameter int PIXEL_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [PIXEL_WIDTH-1:0] pixel_out;
	logic                          was_replaced;
	logic                          frame_end_out;

	modport source (output valid, output pixel_out, output was_replaced,
		output frame_end_out, input ready);
	modport sink   (input valid, input pixel_out, input was_replaced,
		input frame_end_out, output ready);
endinterface

/* hw/rtl/neighbor_outlier_pixel_filter_core.sv */
// A result passes the input register, the slot buffer and the output register.
// Throughput: one pixel per cycle while each transfer releases one result and results is ready;
// a transfer that releases n results (three on a frame's fourth pixel, two on the last pixel of a
// longer frame, up to four for short and four-pixel frames) stalls the input while a four-slot
// result buffer drains one per cycle, itself held while results is not ready. Reset clears
// valids, frame position, buffer count and the outlier level; stored pixel values are not reset.
module neighbor_outlier_pixel_filter_core #(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [nopf_pkg::LEVEL_WIDTH-1:0]    cfg_wdata,
	nopf_in_if.sink                             pixels,
	nopf_out_if.source                          results
);
	localparam int CW = nopf_pkg::COUNT_WIDTH;

	logic [nopf_pkg::LEVEL_WIDTH-1:0] level_q;
	nopf_pkg::burst_ctl_t             ctl;
	logic                             burst_free;
	logic signed [PIXEL_WIDTH-1:0]    slot_cand  [nopf_pkg::SLOT_COUNT];
	logic signed [PIXEL_WIDTH-1:0]    slot_left  [nopf_pkg::SLOT_COUNT];
	logic signed [PIXEL_WIDTH-1:0]    slot_right [nopf_pkg::SLOT_COUNT];
	nopf_pkg::slot_flags_t            slot_flags [nopf_pkg::SLOT_COUNT];

	// Hold the outlier level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_we) begin
			level_q <= cfg_wdata;
		end
	end

	nopf_track #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.level      (level_q),
		.pixels     (pixels),
		.burst_free (burst_free),
		.ctl        (ctl),
		.slot_cand  (slot_cand),
		.slot_left  (slot_left),
		.slot_right (slot_right),
		.slot_flags (slot_flags)
	);

	nopf_burst #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.level      (level_q),
		.ctl        (ctl),
		.slot_cand  (slot_cand),
		.slot_left  (slot_left),
		.slot_right (slot_right),
		.slot_flags (slot_flags),
		.burst_free (burst_free),
		.results    (results)
	);

`ifndef SYNTHESIS
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> burst_free)
		else $error("result slots loaded while buffer still holds results");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (ctl.count <= CW'(nopf_pkg::SLOT_COUNT)))
		else $error("burst count exceeds slot count");
`endif
endmodule

/* hw/rtl/nopf_judge.sv */
// Spike test of one pixel against two neighbors, with floor mean replacement.
module nopf_judge #(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic signed [PIXEL_WIDTH-1:0]           cand,
	input  logic signed [PIXEL_WIDTH-1:0]           left,
	input  logic signed [PIXEL_WIDTH-1:0]           right,
	input  logic        [nopf_pkg::LEVEL_WIDTH-1:0] level,
	output logic signed [PIXEL_WIDTH-1:0]           result,
	output logic                                    replaced
);
	localparam int DW = PIXEL_WIDTH + 1;
	localparam int CW = (DW > nopf_pkg::LEVEL_WIDTH) ? DW : nopf_pkg::LEVEL_WIDTH;

	logic signed [DW-1:0] diff_l;
	logic signed [DW-1:0] diff_r;
	logic signed [DW-1:0] sum;
	logic signed [DW-1:0] mean;
	logic        [DW-1:0] mag_l;
	logic        [DW-1:0] mag_r;
	logic        [CW-1:0] mag_l_w;
	logic        [CW-1:0] mag_r_w;
	logic        [CW-1:0] level_w;

	// Differences to both neighbors, one bit wider so they cannot wrap
	assign diff_l = {cand[PIXEL_WIDTH-1], cand} - {left[PIXEL_WIDTH-1], left};
	assign diff_r = {cand[PIXEL_WIDTH-1], cand} - {right[PIXEL_WIDTH-1], right};
	assign mag_l  = diff_l[DW-1] ? $unsigned(-diff_l) : $unsigned(diff_l);
	assign mag_r  = diff_r[DW-1] ? $unsigned(-diff_r) : $unsigned(diff_r);

	assign mag_l_w = CW'(mag_l);
	assign mag_r_w = CW'(mag_r);
	assign level_w = CW'(level);

	// Spike when far from both sides; a zero level disables the filter
	assign replaced = (level != '0) && (mag_l_w >= level_w) && (mag_r_w >= level_w);

	// Floor mean of the neighbors
	assign sum  = {left[PIXEL_WIDTH-1], left} + {right[PIXEL_WIDTH-1], right};
	assign mean = sum >>> 1;

	assign result = replaced ? mean[PIXEL_WIDTH-1:0] : cand;
endmodule

/* hw/rtl/nopf_track.sv */
// Input register, frame position tracking and per-pixel decisions into result slots.
module nopf_track #(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic        [nopf_pkg::LEVEL_WIDTH-1:0] level,
	nopf_in_if.sink                                 pixels,
	input  logic                                    burst_free,
	output nopf_pkg::burst_ctl_t                    ctl,
	output logic signed [PIXEL_WIDTH-1:0]           slot_cand  [nopf_pkg::SLOT_COUNT],
	output logic signed [PIXEL_WIDTH-1:0]           slot_left  [nopf_pkg::SLOT_COUNT],
	output logic signed [PIXEL_WIDTH-1:0]           slot_right [nopf_pkg::SLOT_COUNT],
	output nopf_pkg::slot_flags_t                   slot_flags [nopf_pkg::SLOT_COUNT]
);
	localparam int PW = nopf_pkg::POS_WIDTH;
	localparam int CW = nopf_pkg::COUNT_WIDTH;

	logic                          v_s1;
	logic signed [PIXEL_WIDTH-1:0] pix_s1;
	logic                          end_s1;

	logic [PW-1:0]                 pos_q;
	logic signed [PIXEL_WIDTH-1:0] head_q [nopf_pkg::HEAD_DEPTH];
	logic signed [PIXEL_WIDTH-1:0] prev_q;
	logic signed [PIXEL_WIDTH-1:0] pend_q;

	logic                          adv;
	logic                          is_short;
	logic                          is_head;
	logic signed [PIXEL_WIDTH-1:0] ja_cand;
	logic signed [PIXEL_WIDTH-1:0] ja_left;
	logic signed [PIXEL_WIDTH-1:0] ja_right;
	logic signed [PIXEL_WIDTH-1:0] fa;
	logic signed [PIXEL_WIDTH-1:0] fb;
	logic                          ra;
	logic                          rb;
	logic [CW-1:0]                 count;

	// Advance the input register whenever the result buffer can take its slots
	assign adv          = v_s1 & burst_free;
	assign pixels.ready = !v_s1 | burst_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pixels.ready) begin
			v_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.ready && pixels.valid) begin
			pix_s1 <= pixels.pixel_in;
			end_s1 <= pixels.frame_end_in;
		end
	end

	assign is_short = pos_q < nopf_pkg::POS_HEAD_DONE;
	assign is_head  = pos_q == nopf_pkg::POS_HEAD_DONE;

	// First decision: pixel 1 on head entry, else the pending raw pixel
	assign ja_cand  = is_head ? head_q[1] : pend_q;
	assign ja_left  = is_head ? head_q[0] : prev_q;
	assign ja_right = is_head ? head_q[2] : pix_s1;

	nopf_judge #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_judge_a (
		.cand     (ja_cand),
		.left     (ja_left),
		.right    (ja_right),
		.level    (level),
		.result   (fa),
		.replaced (ra)
	);

	// Second decision on head entry: pixel 2 against final pixel 1 and the new raw pixel
	nopf_judge #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_judge_b (
		.cand     (head_q[2]),
		.left     (fa),
		.right    (pix_s1),
		.level    (level),
		.result   (fb),
		.replaced (rb)
	);

	// Build slots; frames over three pixels judge pixel 0 and the last pixel on drain
	always_comb begin
		count = '0;
		for (int i = 0; i < nopf_pkg::SLOT_COUNT; i++) begin
			slot_cand[i]  = pix_s1;
			slot_left[i]  = pix_s1;
			slot_right[i] = pix_s1;
			slot_flags[i] = '0;
		end
		if (is_short) begin
			if (end_s1) begin
				count = CW'(pos_q) + CW'(1);
				for (int i = 0; i < nopf_pkg::HEAD_DEPTH; i++) begin
					if (PW'(i) < pos_q) begin
						slot_cand[i] = head_q[i];
					end
				end
				for (int i = 0; i < nopf_pkg::SLOT_COUNT; i++) begin
					if (PW'(i) == pos_q) begin
						slot_flags[i].last = 1'b1;
					end
				end
			end
		end else if (is_head) begin
			count = end_s1 ? CW'(nopf_pkg::SLOT_COUNT) : CW'(nopf_pkg::SLOT_COUNT - 1);
			slot_cand[0]           = head_q[0];
			slot_left[0]           = fa;
			slot_right[0]          = fb;
			slot_flags[0].judge    = 1'b1;
			slot_cand[1]           = fa;
			slot_flags[1].replaced = ra;
			slot_cand[2]           = fb;
			slot_flags[2].replaced = rb;
			slot_left[3]           = fb;
			slot_right[3]          = fa;
			slot_flags[3].judge    = 1'b1;
			slot_flags[3].last     = 1'b1;
		end else begin
			count = end_s1 ? CW'(2) : CW'(1);
			slot_cand[0]           = fa;
			slot_flags[0].replaced = ra;
			slot_left[1]           = fa;
			slot_right[1]          = prev_q;
			slot_flags[1].judge    = 1'b1;
			slot_flags[1].last     = 1'b1;
		end
	end

	assign ctl.load  = adv;
	assign ctl.count = count;

	// Advance the frame position; restart after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (adv) begin
			if (end_s1) begin
				pos_q <= '0;
			end else if (is_short) begin
				pos_q <= pos_q + PW'(1);
			end else begin
				pos_q <= nopf_pkg::POS_STEADY;
			end
		end
	end

	// Hold head pixels and the last final and pending raw pixel
	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_short) begin
				for (int i = 0; i < nopf_pkg::HEAD_DEPTH; i++) begin
					if (PW'(i) == pos_q) begin
						head_q[i] <= pix_s1;
					end
				end
			end else if (is_head) begin
				prev_q <= fb;
				pend_q <= pix_s1;
			end else begin
				prev_q <= fa;
				pend_q <= pix_s1;
			end
		end
	end
endmodule

/* hw/rtl/nopf_burst.sv */
// Result slots drained one per cycle while the output register is free or taken.
module nopf_burst #(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic        [nopf_pkg::LEVEL_WIDTH-1:0] level,
	input  nopf_pkg::burst_ctl_t                    ctl,
	input  logic signed [PIXEL_WIDTH-1:0]           slot_cand  [nopf_pkg::SLOT_COUNT],
	input  logic signed [PIXEL_WIDTH-1:0]           slot_left  [nopf_pkg::SLOT_COUNT],
	input  logic signed [PIXEL_WIDTH-1:0]           slot_right [nopf_pkg::SLOT_COUNT],
	input  nopf_pkg::slot_flags_t                   slot_flags [nopf_pkg::SLOT_COUNT],
	output logic                                    burst_free,
	nopf_out_if.source                              results
);
	localparam int CW = nopf_pkg::COUNT_WIDTH;
	localparam int IW = nopf_pkg::SLOT_IDX_WIDTH;

	logic signed [PIXEL_WIDTH-1:0] cand_q  [nopf_pkg::SLOT_COUNT];
	logic signed [PIXEL_WIDTH-1:0] left_q  [nopf_pkg::SLOT_COUNT];
	logic signed [PIXEL_WIDTH-1:0] right_q [nopf_pkg::SLOT_COUNT];
	nopf_pkg::slot_flags_t         flags_q [nopf_pkg::SLOT_COUNT];
	logic [CW-1:0]                 rem_q;
	logic [IW-1:0]                 idx_q;

	logic                          out_v_q;
	logic signed [PIXEL_WIDTH-1:0] out_pix_q;
	logic                          out_rep_q;
	logic                          out_end_q;

	logic                          drain;
	logic signed [PIXEL_WIDTH-1:0] sel_cand;
	logic signed [PIXEL_WIDTH-1:0] sel_left;
	logic signed [PIXEL_WIDTH-1:0] sel_right;
	nopf_pkg::slot_flags_t         sel_flags;
	logic signed [PIXEL_WIDTH-1:0] j_res;
	logic                          j_rep;

	// Move one slot per cycle while the output register is free or being taken
	assign drain      = (rem_q != '0) && (!out_v_q || results.ready);
	assign burst_free = (rem_q == '0) || ((rem_q == CW'(1)) && drain);

	assign sel_cand  = cand_q[idx_q];
	assign sel_left  = left_q[idx_q];
	assign sel_right = right_q[idx_q];
	assign sel_flags = flags_q[idx_q];

	// Late decision for pixel 0 and the frame's last pixel
	nopf_judge #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_judge (
		.cand     (sel_cand),
		.left     (sel_left),
		.right    (sel_right),
		.level    (level),
		.result   (j_res),
		.replaced (j_rep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				rem_q <= ctl.count;
				idx_q <= '0;
			end else if (drain) begin
				rem_q <= rem_q - CW'(1);
				idx_q <= idx_q + IW'(1);
			end
			if (drain) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Capture slots and the result payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cand_q  <= slot_cand;
			left_q  <= slot_left;
			right_q <= slot_right;
			flags_q <= slot_flags;
		end
		if (drain) begin
			out_pix_q <= sel_flags.judge ? j_res : sel_cand;
			out_rep_q <= sel_flags.judge ? j_rep : sel_flags.replaced;
			out_end_q <= sel_flags.last;
		end
	end

	assign results.valid         = out_v_q;
	assign results.pixel_out     = out_pix_q;
	assign results.was_replaced  = out_rep_q;
	assign results.frame_end_out = out_end_q;
endmodule
